>>> rtl/pacl_pkg.sv
// ----------------------------------------------------------------------------
// pacl_pkg
// Shared types, codes and constants of the PIN access checker.
// ----------------------------------------------------------------------------
package pacl_pkg;

  localparam int unsigned USER_SLOTS_DEF   = 16;
  localparam logic [7:0]  MAX_FAIL_RESET   = 8'd5;
  localparam logic [15:0] LOCK_SECS_RESET  = 16'd300;
  localparam logic [16:0] SECONDS_PER_DAY  = 17'd86400;
  localparam int unsigned CFG_W            = 16;
  localparam int unsigned CFG_IDX_W        = 1;

  typedef enum logic [1:0] {
    REQ_VALIDATE = 2'd0,
    REQ_ADD      = 2'd1,
    REQ_DELETE   = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_UNLIMITED = 2'd0,
    KIND_DATE      = 2'd1,
    KIND_COUNT     = 2'd2,
    KIND_ONCE      = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_GRANTED   = 4'd0,
    ST_LOCKED    = 4'd1,
    ST_DATE_EXP  = 4'd2,
    ST_COUNT_EXP = 4'd3,
    ST_DAY_DENY  = 4'd4,
    ST_TIME_DENY = 4'd5,
    ST_INVALID   = 4'd6,
    ST_LOCK_START= 4'd7,
    ST_ADDED     = 4'd8,
    ST_FULL      = 4'd9,
    ST_DELETED   = 4'd10,
    ST_NOT_FOUND = 4'd11,
    ST_DUPLICATE = 4'd12
  } status_t;

  localparam logic [0:0] CFG_MAX_FAIL  = 1'd0;
  localparam logic [0:0] CFG_LOCK_SECS = 1'd1;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DECIDE,
    FSM_COMMIT,
    FSM_OUT
  } fsm_t;

  typedef struct packed {
    logic start;   // clear scan state, latch request
    logic step;    // examine next slot
    logic decide;  // evaluate request on scan result
    logic commit;  // write table and counters
    logic show;    // load output word
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] pin;
    logic [31:0] now_seconds;
    logic [2:0]  weekday;
    logic [10:0] minute_of_day;
    logic [1:0]  user_type;
    logic [15:0] limit_value;
    logic [6:0]  day_mask;
    logic [10:0] window_start;
    logic [10:0] window_end;
  } req_word_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  status;
    logic [3:0]  slot_index;
    logic [4:0]  user_total;
    logic [7:0]  failure_total;
  } rsp_word_t;

endpackage

>>> rtl/pacl_if.sv
// ----------------------------------------------------------------------------
// pacl_req_if / pacl_rsp_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface pacl_req_if;
  import pacl_pkg::*;
  logic      valid;
  logic      ready;
  req_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pacl_rsp_if;
  import pacl_pkg::*;
  logic      valid;
  logic      ready;
  rsp_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pacl_ctrl.sv
// ----------------------------------------------------------------------------
// pacl_ctrl
// Request sequencer: accept, scan slots, decide, commit, deliver.
// ----------------------------------------------------------------------------
module pacl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pacl_pkg::sts_t  sts,
  output pacl_pkg::cmd_t  cmd
);
  import pacl_pkg::*;

  fsm_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) state <= FSM_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE:   if (in_valid) state_next = FSM_SCAN;
      FSM_SCAN:   if (sts.scan_last) state_next = FSM_DECIDE;
      FSM_DECIDE: state_next = FSM_COMMIT;
      FSM_COMMIT: state_next = FSM_OUT;
      FSM_OUT:    if (out_ready) state_next = FSM_IDLE;
      default:    state_next = FSM_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      FSM_IDLE:   begin in_ready = 1'b1; cmd.start = in_valid; end
      FSM_SCAN:   cmd.step = 1'b1;
      FSM_DECIDE: cmd.decide = 1'b1;
      FSM_COMMIT: begin cmd.commit = 1'b1; cmd.show = 1'b1; end
      FSM_OUT:    out_valid = 1'b1;
      default:    ;
    endcase
  end
endmodule

>>> rtl/pacl_dp.sv
// ----------------------------------------------------------------------------
// pacl_dp
// User table, scan, check and counter datapath.
// ----------------------------------------------------------------------------
module pacl_dp #(
  parameter int unsigned USER_SLOTS = pacl_pkg::USER_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pacl_pkg::cmd_t               cmd,
  output pacl_pkg::sts_t               sts,
  input  pacl_pkg::req_word_t          req_in,
  input  logic                         cfg_we,
  input  logic [pacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pacl_pkg::CFG_W-1:0]   cfg_data,
  output pacl_pkg::rsp_word_t          rsp
);
  import pacl_pkg::*;

  localparam int unsigned SW = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int unsigned CW = $clog2(USER_SLOTS + 1);

  // Table fields in memory, active bits in flops
  logic [USER_SLOTS-1:0] active;
  logic [13:0] m_pin  [USER_SLOTS];
  logic [1:0]  m_kind [USER_SLOTS];
  logic [33:0] m_exp  [USER_SLOTS];
  logic [15:0] m_uses [USER_SLOTS];
  logic [6:0]  m_days [USER_SLOTS];
  logic [10:0] m_ws   [USER_SLOTS];
  logic [10:0] m_we   [USER_SLOTS];

  logic [7:0]  max_fail;
  logic [15:0] lock_secs;
  logic [CW-1:0] users;
  logic [7:0]  fails;
  logic [33:0] lock_until;

  req_word_t   rq;
  logic [SW:0] scan;
  logic [SW-1:0] hit_slot, free_slot, sel;
  logic hit, has_free;

  // Registered read of selected slot
  logic [1:0]  r_kind;
  logic [33:0] r_exp;
  logic [15:0] r_uses;
  logic [6:0]  r_days;
  logic [10:0] r_ws, r_we;

  // Decision results
  status_t     st;
  logic [SW-1:0] out_slot;
  logic        wr_new, uses_dec, retire, del, clr_fail, inc_fail, set_lock, clr_lock;
  logic [33:0] new_exp, lock_val;
  logic [33:0] days_sec;
  logic [15:0] new_uses;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fail  <= MAX_FAIL_RESET;
      lock_secs <= LOCK_SECS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_FAIL) max_fail <= cfg_data[7:0];
      else                           lock_secs <= cfg_data;
    end
  end

  assign sel = hit ? hit_slot : free_slot;
  assign sts.scan_last = (scan == (SW+1)'(USER_SLOTS - 1));

  // Latch request, scan one slot a cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rq <= req_in;
    end
    if (rst) begin
      scan <= '0; hit <= 1'b0; has_free <= 1'b0;
    end else if (cmd.start) begin
      scan <= '0; hit <= 1'b0; has_free <= 1'b0;
    end else if (cmd.step) begin
      if (active[scan[SW-1:0]] && m_pin[scan[SW-1:0]] == rq.pin && !hit) begin
        hit <= 1'b1; hit_slot <= scan[SW-1:0];
      end
      if (!active[scan[SW-1:0]] && !has_free) begin
        has_free <= 1'b1; free_slot <= scan[SW-1:0];
      end
      if (!sts.scan_last) scan <= scan + 1'b1;
    end
  end

  // Read selected slot at end of scan
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      r_kind <= m_kind[sel]; r_exp <= m_exp[sel]; r_uses <= m_uses[sel];
      r_days <= m_days[sel]; r_ws <= m_ws[sel]; r_we <= m_we[sel];
    end
  end

  // Day count times seconds per day, registered ahead of commit
  always_ff @(posedge clk) begin
    if (cmd.decide) days_sec <= 34'(rq.limit_value) * 34'(SECONDS_PER_DAY);
  end

  // Decide on registered slot data
  always_comb begin
    logic locked_now, win_in, day_ok;
    logic [7:0] f_eff, f_inc;
    locked_now = (lock_until != '0) && ({2'b0, rq.now_seconds} < lock_until);
    clr_lock = (lock_until != '0) && !locked_now;
    f_eff = clr_lock ? 8'd0 : fails;
    f_inc = (f_eff == 8'hFF) ? f_eff : f_eff + 8'd1;
    day_ok = (r_days == '0) || (rq.weekday <= 3'd6 && r_days[rq.weekday]);
    if (r_ws < r_we) win_in = rq.minute_of_day >= r_ws && rq.minute_of_day < r_we;
    else win_in = rq.minute_of_day >= r_ws || rq.minute_of_day < r_we;
    if (r_ws == r_we) win_in = 1'b1;
    st = ST_INVALID; out_slot = '0;
    wr_new = 0; uses_dec = 0; retire = 0; del = 0;
    clr_fail = 0; inc_fail = 0; set_lock = 0;
    new_uses = (rq.user_type == KIND_ONCE) ? 16'd1 :
               (rq.user_type == KIND_COUNT) ? rq.limit_value : 16'd0;
    new_exp  = (rq.user_type == KIND_DATE) ? ({2'b0, rq.now_seconds} + days_sec) : '0;
    lock_val = {2'b0, rq.now_seconds} + {18'b0, lock_secs};
    unique case (req_t'(rq.req_type))
      REQ_VALIDATE: begin
        if (locked_now) st = ST_LOCKED;
        else if (!hit) begin
          inc_fail = 1'b1;
          if (f_inc >= max_fail) begin st = ST_LOCK_START; set_lock = 1'b1; end
          else st = ST_INVALID;
        end else begin
          out_slot = hit_slot;
          if (r_kind == KIND_DATE && {2'b0, rq.now_seconds} > r_exp) st = ST_DATE_EXP;
          else if (r_kind[1] && r_uses == '0) st = ST_COUNT_EXP;
          else begin
            uses_dec = r_kind[1];
            retire = (r_kind == KIND_ONCE) && (r_uses == 16'd1);
            if (!day_ok) st = ST_DAY_DENY;
            else if (!win_in) st = ST_TIME_DENY;
            else begin st = ST_GRANTED; clr_fail = 1'b1; end
          end
        end
      end
      REQ_ADD: begin
        if (!has_free) st = ST_FULL;
        else if (hit) begin st = ST_DUPLICATE; out_slot = hit_slot; end
        else begin st = ST_ADDED; out_slot = free_slot; wr_new = 1'b1; end
      end
      REQ_DELETE: begin
        if (!hit) st = ST_NOT_FOUND;
        else begin st = ST_DELETED; out_slot = hit_slot; del = 1'b1; end
      end
      default: st = ST_INVALID;
    endcase
    if (rq.req_type != REQ_VALIDATE) clr_lock = 1'b0;
  end

  // Commit table writes
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (wr_new) begin
        m_pin[sel] <= rq.pin; m_kind[sel] <= rq.user_type; m_exp[sel] <= new_exp;
        m_uses[sel] <= new_uses; m_days[sel] <= rq.day_mask;
        m_ws[sel] <= rq.window_start; m_we[sel] <= rq.window_end;
      end else if (uses_dec) begin
        m_uses[sel] <= r_uses - 16'd1;
      end
    end
  end

  // Commit counters, active bits and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0; users <= '0; fails <= '0; lock_until <= '0;
    end else if (cmd.commit) begin
      if (wr_new) begin active[sel] <= 1'b1; users <= users + 1'b1; end
      if (del || retire) begin
        active[sel] <= 1'b0;
        if (users != '0) users <= users - 1'b1;
      end
      if (clr_lock) begin lock_until <= '0; fails <= '0; end
      if (clr_fail) fails <= '0;
      if (inc_fail) fails <= (clr_lock ? 8'd0 : fails) == 8'hFF ? 8'hFF :
                             (clr_lock ? 8'd0 : fails) + 8'd1;
      if (set_lock) lock_until <= lock_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.show) begin
      rsp.ok     <= (st == ST_GRANTED) || (st == ST_ADDED) || (st == ST_DELETED);
      rsp.status <= st;
      rsp.slot_index <= 4'(out_slot);
      rsp.failure_total <= inc_fail ? (((clr_lock ? 8'd0 : fails) == 8'hFF) ? 8'hFF :
                             (clr_lock ? 8'd0 : fails) + 8'd1) :
                           (clr_fail || clr_lock) ? 8'd0 : fails;
      rsp.user_total <= 5'(wr_new ? users + 1'b1 :
                           ((del || retire) && users != '0) ? users - 1'b1 : users);
    end
  end
endmodule

>>> rtl/pin_access_checker_with_lockout.sv
// ----------------------------------------------------------------------------
// pin_access_checker_with_lockout
// Keypad PIN checker over a user table with miss-count lockout.
//
//   channel | dir | words
//   req     | in  | req_type, pin, time, add fields
//   rsp     | out | ok, status, slot_index, user_total, failure_total
//   cfg     | in  | max_failures (0), lockout_seconds (1)
//
// A request passes the one-slot-per-cycle table scan, then decide, commit
// and output; the next is taken after the word is taken.
// A stalled response holds the block. Reset is synchronous, active high.
// ----------------------------------------------------------------------------
module pin_access_checker_with_lockout #(
  parameter int unsigned USER_SLOTS = pacl_pkg::USER_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  pacl_req_if.sink                       req,
  pacl_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [pacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pacl_pkg::CFG_W-1:0]     cfg_data
);
  import pacl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pacl_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts, .cmd
  );

  pacl_dp #(.USER_SLOTS(USER_SLOTS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .req_in(req.data),
    .cfg_we, .cfg_index, .cfg_data,
    .rsp(rsp.data)
  );
endmodule

>>> sim/pacl_checker.sv
// ----------------------------------------------------------------------------
// pacl_checker
// Watches the request, response and register ports of the PIN access
// checker. It keeps its own copy of the user table, the miss counter and the
// lockout, predicts one response word per accepted request, and compares
// responses in order against the predictions.
// ----------------------------------------------------------------------------
module pacl_checker (
  input  logic                           clk,
  input  logic                           rst,
  pacl_req_if                            req,
  pacl_rsp_if                            rsp,
  input  logic                           cfg_we,
  input  logic [pacl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pacl_pkg::CFG_W-1:0]     cfg_data,
  output int                             errors,
  output int                             outstanding
);
  import pacl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = USER_SLOTS_DEF;

  // shadow table and counters
  logic        in_use [SLOTS];
  logic [13:0] user_pin [SLOTS];
  kind_t       user_kind [SLOTS];
  logic [33:0] user_expiry [SLOTS];
  logic [15:0] uses_left [SLOTS];
  logic [6:0]  user_days [SLOTS];
  logic [10:0] win_lo [SLOTS];
  logic [10:0] win_hi [SLOTS];
  logic [4:0]  active_total;
  logic [7:0]  miss_count;
  logic [33:0] locked_until;
  logic [7:0]  miss_limit;
  logic [15:0] lock_secs;

  rsp_word_t   pending_rsp[$];

  function automatic int lookup_pin(input logic [13:0] p);
    for (int i = 0; i < SLOTS; i++)
      if (in_use[i] && user_pin[i] == p) return i;
    return -1;
  endfunction

  // compute the response word and update the shadow state
  task automatic access_response(input req_word_t w, output rsp_word_t r);
    status_t st;
    int      s;
    int      i;
    int      free_slot;
    logic    done;
    logic    in_win;
    s = 0;
    st = ST_GRANTED;
    done = 1'b0;
    case (req_t'(w.req_type))
      REQ_VALIDATE: begin
        if (locked_until != 0) begin
          if (34'(w.now_seconds) < locked_until) begin
            st = ST_LOCKED;
            done = 1'b1;
          end else begin
            locked_until = '0;
            miss_count = '0;
          end
        end
        if (!done) begin
          i = lookup_pin(w.pin);
          if (i < 0) begin
            if (miss_count != 8'd255) miss_count++;
            if (miss_count >= miss_limit) begin
              locked_until = 34'(w.now_seconds) + 34'(lock_secs);
              st = ST_LOCK_START;
            end else begin
              st = ST_INVALID;
            end
          end else begin
            s = i;
            if (user_kind[i] == KIND_DATE) begin
              if (34'(w.now_seconds) > user_expiry[i]) st = ST_DATE_EXP;
            end else if (user_kind[i] == KIND_COUNT || user_kind[i] == KIND_ONCE) begin
              if (uses_left[i] == 0) begin
                st = ST_COUNT_EXP;
              end else begin
                uses_left[i]--;
                if (user_kind[i] == KIND_ONCE && uses_left[i] == 0) begin
                  in_use[i] = 1'b0;
                  if (active_total != 0) active_total--;
                end
              end
            end
            // weekday 7 shifts the mask to zero and is denied whenever a day mask is set
            if (st == ST_GRANTED && user_days[i] != 0 &&
                ((user_days[i] >> w.weekday) & 7'd1) == 0)
              st = ST_DAY_DENY;
            if (st == ST_GRANTED && win_lo[i] != win_hi[i]) begin
              if (win_lo[i] < win_hi[i])
                in_win = w.minute_of_day >= win_lo[i] && w.minute_of_day < win_hi[i];
              else
                in_win = w.minute_of_day >= win_lo[i] || w.minute_of_day < win_hi[i];
              if (!in_win) st = ST_TIME_DENY;
            end
            if (st == ST_GRANTED) miss_count = '0;
          end
        end
      end
      REQ_ADD: begin
        free_slot = -1;
        for (int k = 0; k < SLOTS; k++)
          if (!in_use[k] && free_slot < 0) free_slot = k;
        if (free_slot < 0) begin
          st = ST_FULL;
        end else begin
          i = lookup_pin(w.pin);
          if (i >= 0) begin
            s = i;
            st = ST_DUPLICATE;
          end else begin
            in_use[free_slot] = 1'b1;
            user_pin[free_slot] = w.pin;
            user_kind[free_slot] = kind_t'(w.user_type);
            user_expiry[free_slot] = (kind_t'(w.user_type) == KIND_DATE) ?
              34'(w.now_seconds) + 34'(w.limit_value) * 34'(SECONDS_PER_DAY) : '0;
            uses_left[free_slot] = (kind_t'(w.user_type) == KIND_ONCE) ? 16'd1 :
              (kind_t'(w.user_type) == KIND_COUNT) ? w.limit_value : 16'd0;
            user_days[free_slot] = w.day_mask;
            win_lo[free_slot] = w.window_start;
            win_hi[free_slot] = w.window_end;
            active_total++;
            s = free_slot;
            st = ST_ADDED;
          end
        end
      end
      REQ_DELETE: begin
        i = lookup_pin(w.pin);
        if (i < 0) begin
          st = ST_NOT_FOUND;
        end else begin
          in_use[i] = 1'b0;
          if (active_total != 0) active_total--;
          s = i;
          st = ST_DELETED;
        end
      end
      default: st = ST_INVALID;
    endcase
    r.ok = (req_t'(w.req_type) != REQ_UNUSED) &&
           (st == ST_GRANTED || st == ST_ADDED || st == ST_DELETED);
    r.status = st;
    r.slot_index = s[3:0];
    r.user_total = active_total;
    r.failure_total = miss_count;
  endtask

  // track state, predict on each request word, compare each response word
  always @(posedge clk) begin
    rsp_word_t want;
    rsp_word_t got;
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) in_use[k] = 1'b0;
      active_total = '0;
      miss_count = '0;
      locked_until = '0;
      miss_limit = MAX_FAIL_RESET;
      lock_secs = LOCK_SECS_RESET;
      pending_rsp.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_FAIL) miss_limit = cfg_data[7:0];
        else if (cfg_index == CFG_LOCK_SECS) lock_secs = cfg_data;
      end
      if (req.valid && req.ready) begin
        access_response(req.data, want);
        pending_rsp.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        if (pending_rsp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response word %p", got);
        end else begin
          want = pending_rsp.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: expected ok=%0d status=%0d slot=%0d users=%0d ",
                        "misses=%0d, got ok=%0d status=%0d slot=%0d users=%0d misses=%0d"},
                       want.ok, want.status, want.slot_index, want.user_total,
                       want.failure_total, got.ok, got.status, got.slot_index,
                       got.user_total, got.failure_total);
          end
        end
      end
    end
    outstanding = pending_rsp.size();
  end

  initial begin
    errors = 0;
    outstanding = 0;
  end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the PIN access checker: a directed list of adds, deletes,
// lockouts and the expiry, day and window denials, then random requests over
// a small PIN pool under several register settings, with random gaps on both
// channels and a long response stall. The checker module does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
  import pacl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   outstanding;
  int                   cycles;
  int                   hold_cycles;
  int                   stall_left;
  logic                 gaps_on;
  logic [31:0]          clock_now;

  pacl_req_if req_ch ();
  pacl_rsp_if rsp_ch ();

  pin_access_checker_with_lockout dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pacl_checker u_checker (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pin_access_checker_with_lockout test failed");
      $finish;
    end
  end

  // response side: long hold-off first, then short random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic req_word_t mk(input req_t r, input logic [13:0] p,
                                   input logic [31:0] now, input logic [2:0] wd,
                                   input logic [10:0] mins, input kind_t k,
                                   input logic [15:0] lim, input logic [6:0] mask,
                                   input logic [10:0] ws, input logic [10:0] we);
    req_word_t w;
    w.req_type = r;
    w.pin = p;
    w.now_seconds = now;
    w.weekday = wd;
    w.minute_of_day = mins;
    w.user_type = k;
    w.limit_value = lim;
    w.day_mask = mask;
    w.window_start = ws;
    w.window_end = we;
    return w;
  endfunction

  // offer one word, with an optional short gap before it
  task automatic send_word(input req_word_t w);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random request over a small PIN pool so hits, duplicates and misses mix
  function automatic req_word_t rand_word();
    req_word_t w;
    int        pick;
    int        op;
    clock_now = clock_now + $urandom_range(0, 150);
    w.now_seconds = ($urandom_range(0, 30) == 0) ? $urandom : clock_now;
    pick = $urandom_range(0, 19);
    w.pin = (pick == 0) ? 14'($urandom) : (pick == 1) ? 14'd9999 :
            14'($urandom_range(0, 23));
    op = $urandom_range(0, 99);
    w.req_type = (op < 58) ? REQ_VALIDATE : (op < 84) ? REQ_ADD :
                 (op < 97) ? REQ_DELETE : REQ_UNUSED;
    w.weekday = 3'($urandom_range(0, 7));
    w.minute_of_day = ($urandom_range(0, 9) == 0) ? 11'($urandom) :
                      11'($urandom_range(0, 1439));
    w.user_type = 2'($urandom_range(0, 3));
    w.limit_value = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                    16'($urandom_range(0, 3));
    w.day_mask = ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom);
    w.window_start = ($urandom_range(0, 9) == 0) ? 11'($urandom) :
                     11'($urandom_range(0, 1439));
    w.window_end = ($urandom_range(0, 2) == 0) ? w.window_start :
                   ($urandom_range(0, 9) == 0) ? 11'($urandom) :
                   11'($urandom_range(0, 1439));
    return w;
  endfunction

  initial begin
    req_word_t dir[$];
    logic [7:0]  fail_set[4];
    logic [15:0] lock_set[4];
    cycles = 0;
    hold_cycles = 0;
    stall_left = 0;
    gaps_on = 1'b1;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    clock_now = $urandom;
    fail_set = '{8'd5, 8'd1, 8'd255, 8'd3};
    lock_set = '{16'd300, 16'd1, 16'd65535, 16'd40};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: table edges, every status but full, lockout under reset settings
    dir.push_back(mk(REQ_VALIDATE, 14'd0, 32'd0, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd0, 32'd100, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd9999, 32'd100, 3'd0, 11'd0, KIND_DATE,
                     16'hFFFF, 7'h7F, 11'd2047, 11'd2047));
    dir.push_back(mk(REQ_ADD, 14'h3FFF, 32'd100, 3'd0, 11'd0, KIND_COUNT,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd0, 32'd100, 3'd0, 11'd0, KIND_ONCE,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'h3FFF, 32'd110, 3'd1, 11'd5, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd5, 32'd120, 3'd0, 11'd0, KIND_ONCE,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'd5, 32'd130, 3'd6, 11'd1439, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'd5, 32'd131, 3'd6, 11'd1439, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd7, 32'd140, 3'd0, 11'd0, KIND_DATE,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'd7, 32'd141, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd8, 32'd150, 3'd0, 11'd0, KIND_COUNT,
                     16'd3, 7'b0000010, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'd8, 32'd151, 3'd7, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd9, 32'd160, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd1000, 11'd100));
    dir.push_back(mk(REQ_VALIDATE, 14'd9, 32'd161, 3'd2, 11'd500, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'd9, 32'd162, 3'd2, 11'd1439, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_DELETE, 14'd9999, 32'd170, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_DELETE, 14'd1234, 32'd171, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_UNUSED, 14'd0, 32'd172, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    for (int k = 0; k < 5; k++)
      dir.push_back(mk(REQ_VALIDATE, 14'(4000 + k), 32'(200 + k), 3'd0, 11'd0,
                       KIND_UNLIMITED, 16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'd0, 32'd300, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_ADD, 14'd11, 32'hFFFF_FFFF, 3'd0, 11'd0, KIND_DATE,
                     16'hFFFF, 7'd0, 11'd0, 11'd0));
    dir.push_back(mk(REQ_VALIDATE, 14'd11, 32'hFFFF_FFFF, 3'd0, 11'd0, KIND_UNLIMITED,
                     16'd0, 7'd0, 11'd0, 11'd0));
    foreach (dir[k]) send_word(dir[k]);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_MAX_FAIL, CFG_W'(fail_set[ph]));
      write_reg(CFG_LOCK_SECS, lock_set[ph]);
      gaps_on = (ph != 3);
      for (int n = 0; n < 430; n++) begin
        // fill the block against a long response stall
        if (ph == 1 && n == 50) begin
          @(posedge clk);
          hold_cycles = 300;
        end
        // let every pending response out before going on
        if (ph == 2 && n == 200) drain();
        send_word(rand_word());
      end
      drain();
    end

    if (errors == 0)
      $display("pin_access_checker_with_lockout test passed");
    else
      $display("pin_access_checker_with_lockout test failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pacl_pkg.sv
rtl/pacl_if.sv
rtl/pacl_ctrl.sv
rtl/pacl_dp.sv
rtl/pin_access_checker_with_lockout.sv
sim/pacl_checker.sv
sim/tb_top.sv
